// File: src/grid_cell_random_pick_set_macros.svh
// ----------------------------------------------------------------------------
// Grid cell random pick set: assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_RANDOM_PICK_SET_MACROS_SVH
`define GRID_CELL_RANDOM_PICK_SET_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GCRPS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("gcrps assertion failed");

// next-cycle implication
`define GCRPS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("gcrps assertion failed");

`else

`define GCRPS_ASSERT_IMP(name, ante, cons)
`define GCRPS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: src/gcrps_pkg.sv
// ----------------------------------------------------------------------------
// gcrps_pkg
// Types, codes and defaults shared by the grid cell random pick set.
// ----------------------------------------------------------------------------
package gcrps_pkg;

	localparam int DEF_MAX_WIDTH   = 128;
	localparam int DEF_MAX_HEIGHT  = 128;
	localparam int DEF_MAX_ENTRIES = 16384;

	localparam int COORD_W  = 16;
	localparam int RND_W    = 16;
	localparam int CHOSEN_W = 8;
	localparam int COUNT_W  = 15;
	localparam int RANGE_W  = 8;
	localparam int CAP_W    = 15;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_X_RANGE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

	localparam logic [RANGE_W-1:0] RST_X_RANGE  = 8'd128;
	localparam logic [RANGE_W-1:0] RST_Y_RANGE  = 8'd128;
	localparam logic [CAP_W-1:0]   RST_CAPACITY = 15'd16384;

	// -1 marker for choose on an empty set
	localparam logic signed [CHOSEN_W-1:0] NO_CELL = -8'sd1;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_REMOVE   = 2'd1,
		ACT_CHOOSE   = 2'd2,
		ACT_CONTAINS = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_PRESENT = 3'd1,
		ST_FULL    = 3'd2,
		ST_BOUNDS  = 3'd3,
		ST_ABSENT  = 3'd4,
		ST_EMPTY   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_MAPRD,
		S_EVAL,
		S_LIDX,
		S_WRLAST,
		S_WRCELL,
		S_DIV,
		S_PICK
	} state_t;

	typedef struct packed {
		action_t                    action;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
		logic        [RND_W-1:0]    random_value;
	} cmd_t;

	typedef struct packed {
		status_t                    status;
		logic signed [CHOSEN_W-1:0] chosen_x;
		logic signed [CHOSEN_W-1:0] chosen_y;
		logic                       present;
		logic        [COUNT_W-1:0]  entry_count;
	} result_t;

endpackage

// File: src/grid_cell_random_pick_set.sv
// ----------------------------------------------------------------------------
// grid_cell_random_pick_set
// Set of grid cells with add, remove, random choose and membership test.
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low. Its single
// result appears on result for exactly one cycle with done high; the receiver
// cannot stall, so it must take the item in that cycle. Add, contains and a
// failed remove pass S_DECODE, S_MAPRD and S_EVAL; a successful remove goes
// on through S_LIDX, S_WRLAST and S_WRCELL; choose on an empty set answers
// from S_DECODE, else it runs 16 bit-serial remainder steps in S_DIV, then
// S_PICK. busy drops in the strobe cycle, so the next item may follow it.
// After reset the cell map is swept to unqueued, one cell per cycle, over all
// MAX_WIDTH*MAX_HEIGHT cells (16384 by default); busy stays high meanwhile,
// while register writes are taken at any time.
// ----------------------------------------------------------------------------
`include "grid_cell_random_pick_set_macros.svh"

module grid_cell_random_pick_set import gcrps_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int CIW   = $clog2(CELLS);
	localparam int EAW   = $clog2(MAX_ENTRIES);
	localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
	localparam int EW    = XW + YW;

	// configuration
	logic [RANGE_W-1:0] xr_q;
	logic [RANGE_W-1:0] yr_q;
	logic [CAP_W-1:0]   cap_q;

	// control
	state_t           state_q, state_d;
	logic [CIW-1:0]   clr_q;
	logic [CNTW-1:0]  count_q;
	logic             done_q;

	// datapath
	cmd_t             cmd_q;
	logic             ok_q;
	logic [CIW-1:0]   ci_q;
	logic [CIW-1:0]   li_q;
	logic [EAW:0]     map_q;   // {valid, slot}
	logic [EW-1:0]    ent_q;   // {x, y}
	result_t          res_q;

	// memories
	logic [EAW:0]     map_mem [CELLS];
	logic [EW-1:0]    ent_mem [MAX_ENTRIES];

	// control outputs of the sequencer
	logic             map_we, map_re, ent_we, ent_re;
	logic [CIW-1:0]   map_waddr;
	logic [EAW:0]     map_wdata;
	logic [EAW-1:0]   ent_waddr, ent_raddr;
	logic [EW-1:0]    ent_wdata;
	logic             div_start, cnt_inc, cnt_dec, res_load;
	result_t          res_d;
	logic [XW-1:0]    idx_x;
	logic [YW-1:0]    idx_y;

	logic [COORD_W-1:0] rx, ry;
	logic             ok;
	logic [CIW-1:0]   idx;
	logic             map_valid;
	logic [EAW-1:0]   map_slot;
	logic             is_full;
	logic             can_rm;
	logic             empty;
	logic             div_done;
	logic [CNTW-1:0]  div_rem;

	assign rx = cmd_q.coord_x;
	assign ry = cmd_q.coord_y;

	// negative coordinates fail on the sign bit
	assign ok = !rx[COORD_W-1] && !ry[COORD_W-1]
		&& (32'(rx) < 32'(xr_q)) && (32'(rx) < MAX_WIDTH)
		&& (32'(ry) < 32'(yr_q)) && (32'(ry) < MAX_HEIGHT);

	// shared cell index unit: command cell at decode, last entry on remove
	assign idx = CIW'(idx_x * MAX_HEIGHT) + CIW'(idx_y);

	assign map_valid = map_q[EAW];
	assign map_slot  = map_q[EAW-1:0];
	// count >= min(capacity, MAX_ENTRIES)
	assign is_full   = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= MAX_ENTRIES);
	assign can_rm    = ok_q && map_valid && (count_q != '0);
	assign empty     = count_q == '0;

	gcrps_mod_unit #(
		.DIV_W(CNTW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd_q.random_value),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// configuration registers; writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xr_q  <= RST_X_RANGE;
			yr_q  <= RST_Y_RANGE;
			cap_q <= RST_CAPACITY;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_X_RANGE:  xr_q  <= wr_data[RANGE_W-1:0];
				CFG_Y_RANGE:  yr_q  <= wr_data[RANGE_W-1:0];
				CFG_CAPACITY: cap_q <= wr_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CIW'(CELLS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (cmd_q.action == ACT_CHOOSE) state_d = empty ? S_IDLE : S_DIV;
				else state_d = S_MAPRD;
			end
			S_MAPRD:  state_d = S_EVAL;
			S_EVAL: begin
				if (cmd_q.action == ACT_REMOVE && can_rm) state_d = S_LIDX;
				else state_d = S_IDLE;
			end
			S_LIDX:   state_d = S_WRLAST;
			S_WRLAST: state_d = S_WRCELL;
			S_WRCELL: state_d = S_IDLE;
			S_DIV: begin
				if (div_done) state_d = S_PICK;
			end
			S_PICK:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		map_we    = 1'b0;
		map_re    = 1'b0;
		map_waddr = ci_q;
		map_wdata = '0;
		ent_we    = 1'b0;
		ent_re    = 1'b0;
		ent_waddr = EAW'(count_q);
		ent_wdata = {rx[XW-1:0], ry[YW-1:0]};
		ent_raddr = EAW'(count_q - 1'b1);
		div_start = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		res_load  = 1'b0;
		idx_x     = rx[XW-1:0];
		idx_y     = ry[YW-1:0];
		res_d.status      = ST_DONE;
		res_d.chosen_x    = '0;
		res_d.chosen_y    = '0;
		res_d.present     = 1'b0;
		res_d.entry_count = COUNT_W'(count_q);
		unique case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
			end
			S_IDLE: ;
			S_DECODE: begin
				if (cmd_q.action == ACT_CHOOSE) begin
					if (empty) begin
						res_load       = 1'b1;
						res_d.status   = ST_EMPTY;
						res_d.chosen_x = NO_CELL;
						res_d.chosen_y = NO_CELL;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			S_MAPRD: map_re = 1'b1;
			S_EVAL: begin
				unique case (cmd_q.action)
					ACT_ADD: begin
						res_load = 1'b1;
						// full before bounds before duplicate
						priority if (is_full) begin
							res_d.status = ST_FULL;
						end else if (!ok_q) begin
							res_d.status = ST_BOUNDS;
						end else if (map_valid) begin
							res_d.status = ST_PRESENT;
						end else begin
							ent_we    = 1'b1;
							map_we    = 1'b1;
							map_wdata = {1'b1, EAW'(count_q)};
							cnt_inc   = 1'b1;
							res_d.entry_count = COUNT_W'(count_q + 1'b1);
						end
					end
					ACT_REMOVE: begin
						if (can_rm) begin
							ent_re = 1'b1;   // fetch last entry
						end else begin
							res_load     = 1'b1;
							res_d.status = ST_ABSENT;
						end
					end
					ACT_CONTAINS: begin
						res_load      = 1'b1;
						res_d.present = ok_q && map_valid;
					end
					ACT_CHOOSE: ;
					default: ;
				endcase
			end
			S_LIDX: begin
				idx_x = ent_q[EW-1:YW];
				idx_y = ent_q[YW-1:0];
			end
			S_WRLAST: begin
				// last entry moves into the freed slot
				ent_we    = 1'b1;
				ent_waddr = map_slot;
				ent_wdata = ent_q;
				map_we    = 1'b1;
				map_waddr = li_q;
				map_wdata = {1'b1, map_slot};
			end
			S_WRCELL: begin
				// after the move, so removing the last entry ends unqueued
				map_we   = 1'b1;
				cnt_dec  = 1'b1;
				res_load = 1'b1;
				res_d.entry_count = COUNT_W'(count_q - 1'b1);
			end
			S_DIV: begin
				if (div_done) begin
					ent_re    = 1'b1;
					ent_raddr = EAW'(div_rem);
				end
			end
			S_PICK: begin
				res_load       = 1'b1;
				res_d.chosen_x = CHOSEN_W'(ent_q[EW-1:YW]);
				res_d.chosen_y = CHOSEN_W'(ent_q[YW-1:0]);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cnt_inc) count_q <= count_q + 1'b1;
			else if (cnt_dec) count_q <= count_q - 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) cmd_q <= cmd;
		if (state_q == S_DECODE) begin
			ok_q <= ok;
			ci_q <= ok ? idx : '0;
		end
		if (state_q == S_LIDX) li_q <= idx;
		if (res_load) res_q <= res_d;
	end

	// cell slot map
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) map_q <= map_mem[ci_q];
	end

	// entry list
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (ent_re) ent_q <= ent_mem[ent_raddr];
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

	`GCRPS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`GCRPS_ASSERT_IMP(a_div_done_state, div_done, state_q == S_DIV)
	`GCRPS_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE)
	`GCRPS_ASSERT_IMP(a_count_max, 1'b1, 32'(count_q) <= MAX_ENTRIES)

endmodule

// File: src/gcrps_mod_unit.sv
// ----------------------------------------------------------------------------
// gcrps_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gcrps_mod_unit import gcrps_pkg::*; #(
	parameter int DIV_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] rem
);

	localparam int CNT_W = $clog2(RND_W);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [RND_W-1:0] dvd_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[RND_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(RND_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? DIV_W'(trial - {1'b0, div_q}) : DIV_W'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: tb/tb_grid_cell_random_pick_set.sv
// ----------------------------------------------------------------------------
// Testbench for grid_cell_random_pick_set
// Sends add, remove, choose and contains items through the start/busy port,
// mirrors the cell set in a local model, and checks every done strobe
// against the oldest expected result. A directed table comes first, then
// random phases under several grid and capacity settings.
// ----------------------------------------------------------------------------
module tb import gcrps_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// the limit must outlast the quiet post-reset map sweep
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int TAIL_CYCLES    = 25;

	// Directed rows. has_want marks rows whose result is obvious; the rest
	// are checked against the local model.
	typedef struct packed {
		action_t       act;
		logic [15:0]   x;
		logic [15:0]   y;
		logic [15:0]   rnd;
		logic          has_want;
		result_t       want;
	} dir_row_t;

	localparam int DIR_N = 24;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// empty set: choose returns the no-cell marker, remove finds nothing
		'{ACT_CHOOSE,   16'd0,     16'd0,     16'h1234, 1'b1,
			'{ST_EMPTY, NO_CELL, NO_CELL, 1'b0, 15'd0}},
		'{ACT_REMOVE,   16'd0,     16'd0,     16'd0,    1'b1,
			'{ST_ABSENT, 8'sd0, 8'sd0, 1'b0, 15'd0}},
		'{ACT_CONTAINS, 16'd0,     16'd0,     16'd0,    1'b1,
			'{ST_DONE, 8'sd0, 8'sd0, 1'b0, 15'd0}},
		// grid corners, then a duplicate
		'{ACT_ADD,      16'd0,     16'd0,     16'd0,    1'b1,
			'{ST_DONE, 8'sd0, 8'sd0, 1'b0, 15'd1}},
		'{ACT_ADD,      16'd127,   16'd127,   16'd0,    1'b1,
			'{ST_DONE, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_ADD,      16'd0,     16'd0,     16'd0,    1'b1,
			'{ST_PRESENT, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		// just outside the grid, negatives and 16-bit extremes
		'{ACT_ADD,      16'd128,   16'd0,     16'd0,    1'b1,
			'{ST_BOUNDS, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_ADD,      16'd0,     16'd128,   16'd0,    1'b1,
			'{ST_BOUNDS, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_ADD,      16'hFFFF,  16'd5,     16'd0,    1'b1,
			'{ST_BOUNDS, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_ADD,      16'h8000,  16'h7FFF,  16'd0,    1'b1,
			'{ST_BOUNDS, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_ADD,      16'h7FFF,  16'h8000,  16'd0,    1'b1,
			'{ST_BOUNDS, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_CONTAINS, 16'd127,   16'd127,   16'd0,    1'b1,
			'{ST_DONE, 8'sd0, 8'sd0, 1'b1, 15'd2}},
		'{ACT_CONTAINS, 16'hFFFF,  16'hFFFF,  16'd0,    1'b1,
			'{ST_DONE, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		// random value extremes against a two-entry set
		'{ACT_CHOOSE,   16'd0,     16'd0,     16'd0,    1'b1,
			'{ST_DONE, 8'sd0, 8'sd0, 1'b0, 15'd2}},
		'{ACT_CHOOSE,   16'd0,     16'd0,     16'hFFFF, 1'b1,
			'{ST_DONE, 8'sd127, 8'sd127, 1'b0, 15'd2}},
		// remove from the front: last entry is swapped into the hole
		'{ACT_ADD,      16'd5,     16'd7,     16'd0,    1'b0, '0},
		'{ACT_REMOVE,   16'd0,     16'd0,     16'd0,    1'b0, '0},
		'{ACT_CHOOSE,   16'd0,     16'd0,     16'd0,    1'b0, '0},
		'{ACT_REMOVE,   16'd5,     16'd7,     16'd0,    1'b0, '0},
		'{ACT_REMOVE,   16'd5,     16'd7,     16'd0,    1'b0, '0},
		'{ACT_REMOVE,   16'd200,   16'd3,     16'd0,    1'b0, '0},
		'{ACT_CONTAINS, 16'h7FFF,  16'h7FFF,  16'd0,    1'b0, '0},
		'{ACT_REMOVE,   16'd127,   16'd127,   16'd0,    1'b0, '0},
		'{ACT_CHOOSE,   16'd0,     16'd0,     16'hFFFF, 1'b0, '0}
	};

	// Random phases: register values plus the action mix in percent.
	typedef struct packed {
		logic [CFG_W-1:0] x_cfg;
		logic [CFG_W-1:0] y_cfg;
		logic [CFG_W-1:0] cap_cfg;
		int               items;
		int               add_pct;
		int               rem_pct;
		int               pick_pct;
	} phase_t;

	localparam int PHASE_N = 8;
	localparam phase_t PHASES [PHASE_N] = '{
		// registers above their maximum, junk in the upper data bits
		'{15'h7FFF, 15'h7FFF, 15'h7FFF, 300, 50, 20, 15},
		// zero bounds with cells still stored: only choose sees them
		'{15'd0,    15'd0,    15'd5,    100, 25, 25, 25},
		// drain most of the set at full grid
		'{15'd128,  15'd128,  15'd16384, 250, 10, 60, 15},
		// tiny grid and capacity: full and duplicate hit often
		'{15'd4,    15'd4,    15'd10,   300, 40, 30, 15},
		'{15'd1,    15'd1,    15'd1,    150, 40, 30, 15},
		// zero capacity: every add reports full
		'{15'd128,  15'd128,  15'd0,    150, 30, 40, 15},
		'{15'd16,   15'd100,  15'd16384, 300, 45, 25, 15},
		// back to reset values
		'{15'd128,  15'd128,  15'd16384, 200, 40, 30, 15}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cmd_t                 cmd = '0;
	logic                 done;
	result_t              result;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = CFG_X_RANGE;
	logic [CFG_W-1:0]     wr_data = '0;

	// local copy of the cell set
	logic [6:0]  set_x [DEF_MAX_ENTRIES];
	logic [6:0]  set_y [DEF_MAX_ENTRIES];
	logic [14:0] slot_map [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
	bit          cell_held [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
	int          set_count = 0;
	int          lim_x = DEF_MAX_WIDTH;
	int          lim_y = DEF_MAX_HEIGHT;
	int          lim_cap = DEF_MAX_ENTRIES;

	result_t     pending_results [$];
	int          error_count = 0;
	int          quiet_cycles = 0;

	grid_cell_random_pick_set dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Applies one accepted item to the local set and returns its result.
	function automatic result_t apply_action(cmd_t c);
		result_t     r;
		logic [15:0] rx;
		logic [15:0] ry;
		bit          ok;
		logic [13:0] ci;
		logic [13:0] li;
		logic [14:0] slot;
		int          pick;
		rx = c.coord_x;
		ry = c.coord_y;
		// negative coordinates fail on the sign bit
		ok = !rx[15] && !ry[15] && (int'(rx) < lim_x) && (int'(ry) < lim_y);
		ci = {rx[6:0], ry[6:0]};
		r = '0;
		r.status = ST_DONE;
		case (c.action)
			ACT_ADD: begin
				// full is tested before bounds, bounds before duplicate
				if (set_count >= lim_cap)
					r.status = ST_FULL;
				else if (!ok)
					r.status = ST_BOUNDS;
				else if (cell_held[ci])
					r.status = ST_PRESENT;
				else begin
					set_x[set_count] = rx[6:0];
					set_y[set_count] = ry[6:0];
					slot_map[ci] = 15'(set_count);
					cell_held[ci] = 1'b1;
					set_count++;
				end
			end
			ACT_REMOVE: begin
				if (!ok || !cell_held[ci] || set_count == 0)
					r.status = ST_ABSENT;
				else begin
					// last entry fills the freed slot
					slot = slot_map[ci];
					li = {set_x[set_count-1], set_y[set_count-1]};
					set_x[slot] = set_x[set_count-1];
					set_y[slot] = set_y[set_count-1];
					slot_map[li] = slot;
					cell_held[ci] = 1'b0;
					set_count--;
				end
			end
			ACT_CHOOSE: begin
				if (set_count == 0) begin
					r.status = ST_EMPTY;
					r.chosen_x = NO_CELL;
					r.chosen_y = NO_CELL;
				end else begin
					pick = int'(c.random_value) % set_count;
					r.chosen_x = {1'b0, set_x[pick]};
					r.chosen_y = {1'b0, set_y[pick]};
				end
			end
			ACT_CONTAINS: begin
				r.present = ok && cell_held[ci];
			end
		endcase
		r.entry_count = COUNT_W'(set_count);
		return r;
	endfunction

	// Sender gap: mostly none or short, now and then long.
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Mostly inside the grid, some just past the edge, some anywhere.
	function automatic logic [15:0] pick_coord(int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return (lim > 0) ? 16'($urandom_range(0, lim - 1)) : 16'($urandom_range(0, 3));
		else if (r < 90)
			return 16'(lim + $urandom_range(0, 2));
		else
			return 16'($urandom_range(0, 65535));
	endfunction

	function automatic cmd_t make_item(phase_t ph);
		cmd_t c;
		int   r;
		int   idx;
		r = $urandom_range(0, 99);
		c.coord_x = pick_coord(lim_x);
		c.coord_y = pick_coord(lim_y);
		c.random_value = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
			: 16'($urandom_range(0, 65535));
		if (r < ph.add_pct)
			c.action = ACT_ADD;
		else if (r < ph.add_pct + ph.rem_pct)
			c.action = ACT_REMOVE;
		else if (r < ph.add_pct + ph.rem_pct + ph.pick_pct)
			c.action = ACT_CHOOSE;
		else
			c.action = ACT_CONTAINS;
		// remove and contains mostly aim at a stored cell
		if ((c.action == ACT_REMOVE || c.action == ACT_CONTAINS) && set_count > 0
				&& $urandom_range(0, 9) < 7) begin
			idx = $urandom_range(0, set_count - 1);
			c.coord_x = {9'd0, set_x[idx]};
			c.coord_y = {9'd0, set_y[idx]};
		end
		return c;
	endfunction

	// Offers one item, waits for the handshake, then records what it must give.
	task automatic issue(cmd_t c, int gap, bit has_want, result_t want);
		result_t predicted;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predicted = apply_action(c);
		pending_results.push_back(has_want ? want : predicted);
	endtask

	// Drops start and waits until every result is back.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_X_RANGE:  lim_x = (int'(data[7:0]) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH
				: int'(data[7:0]);
			CFG_Y_RANGE:  lim_y = (int'(data[7:0]) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT
				: int'(data[7:0]);
			CFG_CAPACITY: lim_cap = (int'(data) > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES
				: int'(data);
			default: ;
		endcase
	endtask

	task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
			error_count++;
		end
	endtask

	// Result checker: the receiver cannot stall, so every strobe is taken.
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $realtime, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				report_field("status", 16'(want.status), 16'(result.status));
				report_field("chosen_x", 16'(want.chosen_x), 16'(result.chosen_x));
				report_field("chosen_y", 16'(want.chosen_y), 16'(result.chosen_y));
				report_field("present", 16'(want.present), 16'(result.present));
				report_field("entry_count", 16'(want.entry_count), 16'(result.entry_count));
			end
		end
	end

	// Watchdog: any handshake, strobe or register write counts as progress.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 || wr_en === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		cmd_t c;
		bit   steady;
		steady = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table at reset register values. The first item waits out
		// the map sweep on busy.
		for (int i = 0; i < DIR_N; i++) begin
			c.action = DIR_ROWS[i].act;
			c.coord_x = DIR_ROWS[i].x;
			c.coord_y = DIR_ROWS[i].y;
			c.random_value = DIR_ROWS[i].rnd;
			issue(c, sender_gap(), DIR_ROWS[i].has_want, DIR_ROWS[i].want);
		end

		// Random phases; registers change only once the block is drained.
		for (int p = 0; p < PHASE_N; p++) begin
			settle();
			set_reg(CFG_X_RANGE, PHASES[p].x_cfg);
			set_reg(CFG_Y_RANGE, PHASES[p].y_cfg);
			set_reg(CFG_CAPACITY, PHASES[p].cap_cfg);
			for (int i = 0; i < PHASES[p].items; i++) begin
				// now and then a run of back-to-back items
				if (i % 64 == 0)
					steady = ($urandom_range(0, 3) == 0);
				issue(make_item(PHASES[p]), steady ? 0 : sender_gap(), 1'b0, '0);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/gcrps_pkg.sv
src/gcrps_mod_unit.sv
src/grid_cell_random_pick_set.sv
tb/tb_grid_cell_random_pick_set.sv
